@@ hdl/msce_pkg.sv @@
// shared types, codes and CRC helper functions for the multi-standard CRC engine
// no dependencies; imported by the input stage, the crc core and the top level
`default_nettype none

package msce_pkg;

    // algorithm selector codes
    localparam logic [2:0] ALG_CRC32  = 3'd0;
    localparam logic [2:0] ALG_DNP    = 3'd1;
    localparam logic [2:0] ALG_KERMIT = 3'd2;
    localparam logic [2:0] ALG_SHIFT  = 3'd3;
    localparam logic [2:0] ALG_ARC    = 3'd4;
    localparam logic [2:0] ALG_CRC8   = 3'd5;

    // polynomials and fixed values
    localparam logic [31:0] POLY_CRC32  = 32'hEDB8_8320;
    localparam logic [31:0] POLY_DNP    = 32'h0000_A6BC;
    localparam logic [31:0] POLY_KERMIT = 32'h0000_8408;
    localparam logic [15:0] POLY_SHIFT  = 16'h8005;
    localparam logic [31:0] POLY_ARC    = 32'h0000_A001;
    localparam logic [31:0] POLY_CRC8   = 32'h0000_008C;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

    // one byte request as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_item;

    // one byte through a reflected (lsb-first) crc, eight unrolled shifts
    function automatic logic [31:0] f_reflect_byte(
        input logic [31:0] i_reg,
        input logic [7:0]  i_byte,
        input logic [31:0] i_poly
    );
        logic [31:0] v;
        v = i_reg ^ {24'h0, i_byte};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ i_poly) : (v >> 1);
        end
        return v;
    endfunction

    // swap the two low bytes, upper half cleared
    function automatic logic [31:0] f_swap16(input logic [15:0] i_val);
        return {16'h0, i_val[7:0], i_val[15:8]};
    endfunction

endpackage

`default_nettype wire

@@ hdl/msce_in_stage.sv @@
// input register of the crc engine: holds one byte request until the core takes it
// depends on msce_pkg for the request struct
`default_nettype none

module msce_in_stage (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  wire  [7:0]       i_data_byte,
    input  wire              i_first_byte,
    input  wire              i_last_byte,
    output msce_pkg::t_item  o_item,
    output logic             o_item_valid,
    input  wire              i_item_take
);
    import msce_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    // a slot is free when empty or being drained this cycle
    assign o_in_ready = !r_valid || i_item_take;

    always_comb begin
        n_valid = r_valid;
        if (o_in_ready) begin
            n_valid = i_in_valid;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload register, loaded on each accepted request
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.data_byte  <= i_data_byte;
            r_item.first_byte <= i_first_byte;
            r_item.last_byte  <= i_last_byte;
        end
    end

    assign o_item       = r_item;
    assign o_item_valid = r_valid;

endmodule

`default_nettype wire

@@ hdl/msce_crc_core.sv @@
// running crc state and the one-byte update for all six algorithms
// depends on msce_pkg for codes, polynomials and byte update functions
`default_nettype none

module msce_crc_core (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire  [2:0]       i_alg,
    input  msce_pkg::t_item  i_item,
    input  wire              i_fire,
    output logic [31:0]      o_checksum
);
    import msce_pkg::*;

    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [7:0]  r_prev;
    logic [31:0] w_start;
    logic [7:0]  w_prev_start;
    logic [15:0] w_shifted;

    // first byte restarts from the algorithm's initial value
    always_comb begin
        w_start      = r_crc;
        w_prev_start = r_prev;
        if (i_item.first_byte) begin
            w_start      = (i_alg == ALG_CRC32) ? ALL_ONES : 32'h0;
            w_prev_start = 8'h0;
        end
    end

    // shift-register variant: shift with feedback on carry out of bit 15
    assign w_shifted = w_start[15] ? ({w_start[14:0], 1'b0} ^ POLY_SHIFT)
                                   : {w_start[14:0], 1'b0};

    // fold one byte into the running value
    always_comb begin
        case (i_alg)
            ALG_CRC32:  n_crc = f_reflect_byte(w_start, i_item.data_byte, POLY_CRC32);
            ALG_DNP:    n_crc = f_reflect_byte({16'h0, w_start[15:0]}, i_item.data_byte,
                                               POLY_DNP);
            ALG_KERMIT: n_crc = f_reflect_byte({16'h0, w_start[15:0]}, i_item.data_byte,
                                               POLY_KERMIT);
            ALG_SHIFT:  n_crc = {16'h0, w_shifted ^ {w_prev_start, i_item.data_byte}};
            ALG_ARC:    n_crc = f_reflect_byte({16'h0, w_start[15:0]}, i_item.data_byte,
                                               POLY_ARC);
            ALG_CRC8:   n_crc = f_reflect_byte({24'h0, w_start[7:0]}, i_item.data_byte,
                                               POLY_CRC8);
            default:    n_crc = 32'h0;
        endcase
    end

    // final step applied only to the emitted value
    always_comb begin
        case (i_alg)
            ALG_CRC32:  o_checksum = n_crc ^ ALL_ONES;
            ALG_DNP:    o_checksum = f_swap16(~n_crc[15:0]);
            ALG_KERMIT: o_checksum = f_swap16(n_crc[15:0]);
            ALG_SHIFT:  o_checksum = f_swap16(n_crc[15:0]);
            ALG_ARC:    o_checksum = {16'h0, n_crc[15:0]};
            ALG_CRC8:   o_checksum = {24'h0, n_crc[7:0]};
            default:    o_checksum = 32'h0;
        endcase
    end

    // state update on every byte that leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= 32'h0;
            r_prev <= 8'h0;
        end else if (i_fire) begin
            r_crc  <= n_crc;
            r_prev <= i_item.data_byte;
        end
    end

endmodule

`default_nettype wire

@@ hdl/msce_out_stage.sv @@
// result register of the crc engine: holds a finished checksum until taken
// no package dependencies
`default_nettype none

module msce_out_stage (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_load,
    input  wire  [31:0] i_checksum,
    output logic        o_free,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [31:0] o_checksum
);

    logic        r_valid;
    logic        n_valid;
    logic [31:0] r_checksum;

    // free when empty or being taken this cycle
    assign o_free = !r_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // checksum payload
    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_checksum <= i_checksum;
        end
    end

    assign o_out_valid = r_valid;
    assign o_checksum  = r_checksum;

endmodule

`default_nettype wire

@@ hdl/multi_standard_crc_engine.sv @@
// top level of the multi-standard crc engine: config register and stage wiring
// depends on msce_pkg, msce_in_stage, msce_crc_core and msce_out_stage
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one message byte per request
//   with first/last flags. A first byte restarts the CRC from the initial
//   value of the selected algorithm; a last byte produces one checksum
//   request on the output channel (o_out_valid / i_out_ready).
//   Config channel (i_cfg_valid / o_cfg_ready) writes the 3-bit algorithm
//   select; it is always ready and must only be written while idle.
//   A last byte's checksum enters the result register as the byte leaves the
//   input register. Throughput: one byte per cycle unless a last byte waits on a
//   busy result register; the eight-bit unrolled update sets this figure.
//   Reset (synchronous, active low) clears the running CRC and previous byte
//   to zero, the select to CRC-32 and both stages to empty.
//   When the receiver stalls, the finished checksum holds in the result
//   register; the input register still drains bytes that are not last, and
//   a last byte waits there until the result register frees up.
`default_nettype none

module multi_standard_crc_engine (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_first_byte,
    input  wire         i_last_byte,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [31:0] o_checksum,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_algorithm
);
    import msce_pkg::*;

    logic [2:0]  r_alg;
    t_item       w_item;
    logic        w_item_valid;
    logic        w_take;
    logic        w_load;
    logic        w_out_free;
    logic [31:0] w_checksum;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alg <= ALG_CRC32;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_alg <= i_cfg_algorithm;
        end
    end

    // a held byte moves on unless it is last and the result register is busy
    assign w_take = w_item_valid && (!w_item.last_byte || w_out_free);
    assign w_load = w_take && w_item.last_byte;

    msce_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_take  (w_take)
    );

    msce_crc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_alg      (r_alg),
        .i_item     (w_item),
        .i_fire     (w_take),
        .o_checksum (w_checksum)
    );

    msce_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_checksum  (w_checksum),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_checksum  (o_checksum)
    );

    // a last byte blocked by a busy result register stalls the input
    a_last_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_item_valid && w_item.last_byte && !w_out_free |-> !o_in_ready)
        else $error("input accepted while a blocked last byte is held");

    // a new result shows up only after a last byte left the input register
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_load))
        else $error("result appeared without a last byte");

    // narrow algorithms yield a zero upper half
    a_narrow_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && w_out_free && r_alg != ALG_CRC32 |=> o_checksum[31:16] == 16'h0)
        else $error("upper checksum bits set for a narrow algorithm");

endmodule

`default_nettype wire
